// ===== rtl/gpio_serial_rtc_port_macros.svh =====
// Assertion helpers shared by the port RTL.
`ifndef GPIO_SERIAL_RTC_PORT_MACROS_SVH
`define GPIO_SERIAL_RTC_PORT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GSRP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gsrp_pkg.sv =====
`default_nettype none
package gsrp_pkg;

  // Bus write kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DIR  = 2'd1;
  localparam logic [1:0] KIND_CTRL = 2'd2;

  // Pin assignment of the serial clock
  localparam int PIN_SCK = 0;
  localparam int PIN_SIO = 1;
  localparam int PIN_CS  = 2;
  localparam logic [3:0] SIO_MASK = 4'(1) << PIN_SIO;

  // Clock commands
  localparam logic [2:0] CMD_RESET     = 3'd0;
  localparam logic [2:0] CMD_DATETIME  = 3'd2;
  localparam logic [2:0] CMD_FORCE_IRQ = 3'd3;
  localparam logic [2:0] CMD_CONTROL   = 3'd4;
  localparam logic [2:0] CMD_TIME      = 3'd6;
  localparam logic [3:0] CMD_SIGNATURE = 4'h6;

  localparam logic [7:0] RTC_CTRL_RESET   = 8'h40;
  localparam int         RTC_CTRL_24H_BIT = 6;
  localparam logic [7:0] READ_FILL        = 8'hFF;
  localparam logic [6:0] YEAR_MAX         = 7'd99;
  localparam int         SNAP_BYTES       = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] pin_value;
    logic [6:0] clock_year;
    logic [3:0] clock_month;
    logic [4:0] clock_day;
    logic [2:0] clock_weekday;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
  } gsrp_item_t;

  typedef struct packed {
    logic [3:0] data_view;
    logic [3:0] direction_view;
    logic       control_view;
  } gsrp_view_t;

  typedef logic [SNAP_BYTES-1:0][7:0] gsrp_snap_t;

  // Data bytes that follow each command
  function automatic logic [2:0] cmd_byte_count(input logic [2:0] cmd);
    logic [2:0] cnt;
    case (cmd)
      CMD_DATETIME: cnt = 3'd7;
      CMD_CONTROL:  cnt = 3'd1;
      CMD_TIME:     cnt = 3'd3;
      default:      cnt = 3'd0;
    endcase
    return cnt;
  endfunction

  // Binary to two BCD digits; divide by ten via 205/2048 (exact below 180)
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = 15'(v) * 15'd205;
    tens = prod[14:11];
    ones = v - 7'(7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gsrp_wr_if.sv =====
`default_nettype none
interface gsrp_wr_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] pin_value;
  logic [6:0] clock_year;
  logic [3:0] clock_month;
  logic [4:0] clock_day;
  logic [2:0] clock_weekday;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;
  logic [5:0] clock_second;

  modport source (
    output valid, kind, pin_value, clock_year, clock_month, clock_day,
           clock_weekday, clock_hour, clock_minute, clock_second,
    input  ready
  );
  modport sink (
    input  valid, kind, pin_value, clock_year, clock_month, clock_day,
           clock_weekday, clock_hour, clock_minute, clock_second,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/gsrp_view_if.sv =====
`default_nettype none
interface gsrp_view_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_view;
  logic [3:0] direction_view;
  logic       control_view;

  modport source (
    output valid, data_view, direction_view, control_view,
    input  ready
  );
  modport sink (
    input  valid, data_view, direction_view, control_view,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/gpio_serial_rtc_port.sv =====
// GPIO port with serial RTC: bus-write side and view side.
//
// bus_wr (sink): one transfer per bus write to the port. kind selects the
// data, direction or control register; pin_value is the written value; the
// clock_* fields carry the current binary time, sampled when the command
// byte of a command that snapshots the time is received.
// port_view (source): one transfer per bus write, carrying the port
// registers as the bus reads them after that write (all zero while the
// port is not readable).
//
// Path: a bus_wr transfer passes the input register, then the protocol
// step and the view register, before port_view goes valid.
// Throughput: one write per cycle while port_view is not held; the protocol
// step is a single pass of shallow logic on the protocol registers.
// Reset: rst (synchronous) returns the pins, counters and RTC control
// (24-hour mode) to power-up values at once; no clearing pass.
// Stall: while port_view is held, one more write is taken into the input
// register, then bus_wr.ready drops until the view transfer completes.
`default_nettype none
module gpio_serial_rtc_port (
  input logic        clk,
  input logic        rst,
  gsrp_wr_if.sink    bus_wr,
  gsrp_view_if.source port_view
);
  import gsrp_pkg::*;
`include "gpio_serial_rtc_port_macros.svh"

  gsrp_item_t item_q;
  logic       item_valid;
  gsrp_view_t view_q;
  gsrp_view_t view_next;
  logic       view_valid;
  logic       advance;

  // Item moves to the view register when that register is free or drains
  assign advance      = item_valid && (!view_valid || port_view.ready);
  assign bus_wr.ready = !item_valid || advance;

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      view_valid <= 1'b0;
    end else begin
      if (bus_wr.ready) begin
        item_valid <= bus_wr.valid;
      end
      if (advance) begin
        view_valid <= 1'b1;
      end else if (port_view.ready) begin
        view_valid <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (bus_wr.valid && bus_wr.ready) begin
      item_q <= '{kind: bus_wr.kind,
                  pin_value: bus_wr.pin_value,
                  clock_year: bus_wr.clock_year,
                  clock_month: bus_wr.clock_month,
                  clock_day: bus_wr.clock_day,
                  clock_weekday: bus_wr.clock_weekday,
                  clock_hour: bus_wr.clock_hour,
                  clock_minute: bus_wr.clock_minute,
                  clock_second: bus_wr.clock_second};
    end
  end

  gsrp_rtc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (item_q),
    .view_next (view_next)
  );

  // View register
  always_ff @(posedge clk) begin
    if (advance) begin
      view_q <= view_next;
    end
  end

  assign port_view.valid          = view_valid;
  assign port_view.data_view      = view_q.data_view;
  assign port_view.direction_view = view_q.direction_view;
  assign port_view.control_view   = view_q.control_view;

  `GSRP_ASSERT_SAME(a_ready_when_empty, clk, rst, !view_valid, bus_wr.ready,
    "write side stalled with empty view register")
  `GSRP_ASSERT_NEXT(a_item_held, clk, rst, item_valid && !advance, item_valid,
    "pending write lost from input register")
  `GSRP_ASSERT_NEXT(a_view_follows, clk, rst, advance, view_valid,
    "stepped write produced no view")

endmodule
`default_nettype wire

// ===== rtl/gsrp_snap_conv.sv =====
`default_nettype none
module gsrp_snap_conv (
  input  gsrp_pkg::gsrp_item_t item,
  input  logic                 twelve_hour,
  output gsrp_pkg::gsrp_snap_t snap
);
  import gsrp_pkg::*;

  logic [6:0] year_clamped;
  logic [4:0] hour_folded;

  // Year clamp and optional 12-hour fold (no PM flag)
  always_comb begin
    year_clamped = (item.clock_year > YEAR_MAX) ? YEAR_MAX : item.clock_year;
    priority if (twelve_hour && item.clock_hour >= 5'd24) begin
      hour_folded = item.clock_hour - 5'd24;
    end else if (twelve_hour && item.clock_hour >= 5'd12) begin
      hour_folded = item.clock_hour - 5'd12;
    end else begin
      hour_folded = item.clock_hour;
    end
  end

  // BCD bytes in clock readout order
  assign snap[0] = to_bcd(year_clamped);
  assign snap[1] = to_bcd(7'(item.clock_month));
  assign snap[2] = to_bcd(7'(item.clock_day));
  assign snap[3] = to_bcd(7'(item.clock_weekday));
  assign snap[4] = to_bcd(7'(hour_folded));
  assign snap[5] = to_bcd(7'(item.clock_minute));
  assign snap[6] = to_bcd(7'(item.clock_second));

endmodule
`default_nettype wire

// ===== rtl/gsrp_rtc_core.sv =====
`default_nettype none
module gsrp_rtc_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  gsrp_pkg::gsrp_item_t item,
  output gsrp_pkg::gsrp_view_t view_next
);
  import gsrp_pkg::*;
`include "gpio_serial_rtc_port_macros.svh"

  // Port and clock state
  logic [3:0] pin_state, pin_state_next;
  logic [3:0] pin_direction, pin_direction_next;
  logic [3:0] output_latch, output_latch_next;
  logic       readable_flag, readable_flag_next;
  logic [7:0] shift_bits, shift_bits_next;
  logic [2:0] bit_count, bit_count_next;
  logic [2:0] bytes_left, bytes_left_next;
  logic [2:0] active_command, active_command_next;
  logic       command_busy, command_busy_next;
  logic       read_mode, read_mode_next;
  logic       sck_previous, sck_previous_next;
  logic       sio_drive, sio_drive_next;
  logic [7:0] rtc_control_reg, rtc_control_reg_next;
  gsrp_snap_t time_snapshot, time_snapshot_next;

  gsrp_snap_t snap_fresh;
  logic [3:0] merged;
  logic [3:0] drive;
  logic       cs, sck, sio;
  logic [7:0] read_byte;
  logic [2:0] bit_count_inc;
  logic [2:0] bytes_dec;
  logic [2:0] new_command;

  gsrp_snap_conv u_conv (
    .item        (item),
    .twelve_hour (!rtc_control_reg[RTC_CTRL_24H_BIT]),
    .snap        (snap_fresh)
  );

  // Byte the clock sends in the read phase
  always_comb begin
    priority if (active_command == CMD_CONTROL) begin
      read_byte = rtc_control_reg;
    end else if (active_command == CMD_DATETIME && bytes_left != 3'd0) begin
      read_byte = time_snapshot[3'(SNAP_BYTES) - bytes_left];
    end else if (active_command == CMD_TIME && bytes_left != 3'd0 &&
                 bytes_left <= 3'd3) begin
      read_byte = time_snapshot[3'(SNAP_BYTES) - bytes_left];
    end else begin
      read_byte = READ_FILL;
    end
  end

  assign bit_count_inc = bit_count + 3'd1;
  assign bytes_dec     = (bytes_left != 3'd0) ? bytes_left - 3'd1 : 3'd0;
  assign new_command   = shift_bits[6:4];

  // Pin merge and one step of the serial protocol per data or direction write; control writes set the readable flag
  always_comb begin
    pin_state_next       = pin_state;
    pin_direction_next   = pin_direction;
    output_latch_next    = output_latch;
    readable_flag_next   = readable_flag;
    shift_bits_next      = shift_bits;
    bit_count_next       = bit_count;
    bytes_left_next      = bytes_left;
    active_command_next  = active_command;
    command_busy_next    = command_busy;
    read_mode_next       = read_mode;
    sck_previous_next    = sck_previous;
    sio_drive_next       = sio_drive;
    rtc_control_reg_next = rtc_control_reg;
    time_snapshot_next   = time_snapshot;
    merged               = '0;
    drive                = '0;
    cs                   = 1'b0;
    sck                  = 1'b0;
    sio                  = 1'b0;

    if (fire) begin
      unique case (item.kind)
        KIND_DATA, KIND_DIR: begin
          if (item.kind == KIND_DATA) begin
            output_latch_next = item.pin_value;
          end else begin
            pin_direction_next = item.pin_value;
          end
          merged = (output_latch_next & pin_direction_next) |
                   (pin_state & ~pin_direction_next);
          drive  = merged & SIO_MASK;
          cs     = merged[PIN_CS];
          sck    = merged[PIN_SCK];
          sio    = merged[PIN_SIO];

          if (!cs) begin
            // chip deselected: protocol back to idle, SIO pulled high
            bit_count_next      = '0;
            bytes_left_next     = '0;
            command_busy_next   = 1'b0;
            active_command_next = CMD_RESET;
            sio_drive_next      = 1'b1;
            drive               = SIO_MASK;
          end else if (!command_busy || !read_mode) begin
            // command or write-data phase
            if (!sck) begin
              shift_bits_next[bit_count] = sio;
            end else if (!sck_previous) begin
              if (bit_count == 3'd7) begin
                bit_count_next  = '0;
                shift_bits_next = '0;
                if (!command_busy) begin
                  if (shift_bits[3:0] == CMD_SIGNATURE) begin
                    active_command_next = new_command;
                    read_mode_next      = shift_bits[7];
                    bytes_left_next     = cmd_byte_count(new_command);
                    command_busy_next   = (cmd_byte_count(new_command) != 3'd0);
                    if (new_command == CMD_RESET) begin
                      rtc_control_reg_next = '0;
                    end
                    if (new_command == CMD_DATETIME || new_command == CMD_TIME) begin
                      time_snapshot_next = snap_fresh;
                    end
                  end
                end else begin
                  if (active_command == CMD_CONTROL) begin
                    rtc_control_reg_next = shift_bits;
                  end
                  bytes_left_next   = bytes_dec;
                  command_busy_next = (bytes_dec != 3'd0);
                end
              end else begin
                bit_count_next = bit_count_inc;
              end
            end
          end else begin
            // read phase: next bit out on falling SCK
            if (sck_previous && !sck) begin
              sio_drive_next = read_byte[bit_count];
              if (bit_count == 3'd7) begin
                bit_count_next    = '0;
                bytes_left_next   = bytes_dec;
                command_busy_next = (bytes_dec != 3'd0);
              end else begin
                bit_count_next = bit_count_inc;
              end
            end
            drive = sio_drive_next ? SIO_MASK : 4'd0;
          end

          sck_previous_next = sck;
          pin_state_next    = (merged & pin_direction_next) |
                              (drive & ~pin_direction_next);
        end
        KIND_CTRL: begin
          readable_flag_next = item.pin_value[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Bus view after this transfer
  always_comb begin
    if (readable_flag_next) begin
      view_next = '{data_view: pin_state_next,
                    direction_view: pin_direction_next,
                    control_view: 1'b1};
    end else begin
      view_next = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_state       <= '0;
      pin_direction   <= '0;
      output_latch    <= '0;
      readable_flag   <= 1'b0;
      shift_bits      <= '0;
      bit_count       <= '0;
      bytes_left      <= '0;
      active_command  <= CMD_RESET;
      command_busy    <= 1'b0;
      read_mode       <= 1'b0;
      sck_previous    <= 1'b1;
      sio_drive       <= 1'b1;
      rtc_control_reg <= RTC_CTRL_RESET;
      time_snapshot   <= '0;
    end else if (fire) begin
      pin_state       <= pin_state_next;
      pin_direction   <= pin_direction_next;
      output_latch    <= output_latch_next;
      readable_flag   <= readable_flag_next;
      shift_bits      <= shift_bits_next;
      bit_count       <= bit_count_next;
      bytes_left      <= bytes_left_next;
      active_command  <= active_command_next;
      command_busy    <= command_busy_next;
      read_mode       <= read_mode_next;
      sck_previous    <= sck_previous_next;
      sio_drive       <= sio_drive_next;
      rtc_control_reg <= rtc_control_reg_next;
      time_snapshot   <= time_snapshot_next;
    end
  end

  `GSRP_ASSERT_SAME(a_busy_has_bytes, clk, rst, command_busy, bytes_left != 3'd0,
    "busy command with no bytes left")
  `GSRP_ASSERT_NEXT(a_cs_low_idles, clk, rst,
    fire && (item.kind == KIND_DATA || item.kind == KIND_DIR) && !merged[PIN_CS],
    bit_count == 3'd0 && !command_busy && sio_drive,
    "chip deselect did not idle the protocol")
  `GSRP_ASSERT_NEXT(a_ctrl_keeps_pins, clk, rst, fire && item.kind == KIND_CTRL,
    $stable(pin_state) && $stable(bit_count) && $stable(command_busy),
    "control write disturbed pin or protocol state")

endmodule
`default_nettype wire
